>>> src/pfa_pkg.sv
package pfa_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int CMD_W   = 1;
    localparam int INDEX_W = 4;
    localparam int REQ_W   = 16;
    localparam int POL_W   = 2;
    localparam int COUNT_W = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [POL_W-1:0]   POL_FIRST     = 2'd0;
    localparam logic [POL_W-1:0]   POL_BEST      = 2'd1;
    localparam logic [POL_W-1:0]   POL_WORST     = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 5'd16;

    localparam logic [CMD_W-1:0] CMD_LOAD     = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOCATE = 1'b1;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [POL_W-1:0]   fit_policy;
        logic [COUNT_W-1:0] blocks_in_use;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage

>>> src/pfa_cfg.sv
module pfa_cfg
    import pfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic s_wr;

    assign s_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_policy    <= POL_FIRST;
            r_cfg.blocks_in_use <= COUNT_RESET;
        end else if (s_wr) begin
            case (paddr[2])
                REG_POLICY: r_cfg.fit_policy    <= pwdata[POL_W-1:0];
                REG_COUNT:  r_cfg.blocks_in_use <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_POLICY: prdata[POL_W-1:0]   = r_cfg.fit_policy;
            REG_COUNT:  prdata[COUNT_W-1:0] = r_cfg.blocks_in_use;
            default:    prdata = '0;
        endcase
    end

endmodule

>>> src/partition_fit_allocator_core.sv
// Channel   Direction  Signals                                        Moves
// in        input      i_in_valid, o_in_ready                         one command request
//                      i_command, i_block_index, i_size
// out       output     o_out_valid, i_out_ready                       one allocation result
//                      o_granted, o_block_number, o_left_over
// cfg       APB        psel, penable, pwrite, paddr, pwdata,          fit_policy at 0,
//                      prdata, pready                                 blocks_in_use at 4
//
// A load request writes the block memory directly when it is accepted.
// An allocate request reads min(blocks_in_use, NUM_BLOCKS) blocks, one block memory read
// per cycle, then waits out the read latency, then has a write-back step.
// With no block to search or the unused policy it skips the scan and goes to the result.
// A request is taken only while no allocation is in progress; a waiting result stalls only a
// following allocation, at its write-back cycle. Reset clears control state, not the memory.
module partition_fit_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [INDEX_W-1:0] i_block_index,
    input  logic [REQ_W-1:0]   i_size,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_granted,
    output logic [INDEX_W-1:0] o_block_number,
    output logic [REQ_W-1:0]   o_left_over,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    t_cfg s_cfg;

    pfa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    logic [SIZE_WIDTH:0] mem [NUM_BLOCKS];

    t_state r_state, n_state;
    logic [IDX_W-1:0]      r_addr;
    logic [SIZE_WIDTH-1:0] r_req;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [SIZE_WIDTH:0]   r_rd_word;
    logic                  r_have;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_WIDTH-1:0] r_pick_size;
    logic                  r_pick_tk;
    logic                  r_out_valid;
    logic                  r_out_granted;
    logic [INDEX_W-1:0]    r_out_block;
    logic [REQ_W-1:0]      r_out_left;

    logic                      s_accept;
    logic                      s_out_free;
    logic                      s_finish;
    logic [CNT_W-1:0]          s_n;
    logic                      s_last;
    logic [SIZE_WIDTH+REQ_W-1:0] s_req_ext;
    logic [SIZE_WIDTH-1:0]     s_req;
    logic [IDX_W+INDEX_W-1:0]  s_idx_ext;
    logic                      s_load_ok;
    logic [SIZE_WIDTH-1:0]     s_rd_size;
    logic                      s_rd_tk;
    logic                      s_fits;
    logic                      s_take;
    logic                      s_grant;
    logic [SIZE_WIDTH-1:0]     s_left;
    logic [SIZE_WIDTH+REQ_W-1:0] s_left_ext;
    logic [IDX_W+INDEX_W-1:0]  s_pick_ext;
    logic                      s_we;
    logic [IDX_W-1:0]          s_waddr;
    logic [SIZE_WIDTH:0]       s_wdata;

    assign o_in_ready = (r_state == ST_IDLE);
    assign s_accept   = i_in_valid & o_in_ready;
    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_finish   = (r_state == ST_DONE) && s_out_free;

    always_comb begin
        if (int'(s_cfg.blocks_in_use) > NUM_BLOCKS) begin
            s_n = CNT_W'(NUM_BLOCKS);
        end else begin
            s_n = CNT_W'(s_cfg.blocks_in_use);
        end
    end

    assign s_last    = (CNT_W'(r_addr) + CNT_W'(1)) == s_n;
    assign s_req_ext = {{SIZE_WIDTH{1'b0}}, i_size};
    assign s_req     = s_req_ext[SIZE_WIDTH-1:0];
    assign s_idx_ext = {{IDX_W{1'b0}}, i_block_index};
    assign s_load_ok = int'(i_block_index) < NUM_BLOCKS;

    assign s_rd_size = r_rd_word[SIZE_WIDTH-1:0];
    assign s_rd_tk   = r_rd_word[SIZE_WIDTH];
    assign s_fits    = !s_rd_tk && (s_rd_size >= r_req);

    always_comb begin
        case (s_cfg.fit_policy)
            POL_FIRST: s_take = s_fits && !r_have;
            POL_BEST:  s_take = s_fits && (!r_have || (s_rd_size < r_pick_size));
            POL_WORST: s_take = !r_have || (s_rd_size > r_pick_size);
            default:   s_take = 1'b0;
        endcase
    end

    assign s_grant    = r_have &&
                        ((s_cfg.fit_policy != POL_WORST) || (r_pick_size >= r_req));
    assign s_left     = r_pick_size - r_req;
    assign s_left_ext = {{REQ_W{1'b0}}, s_left};
    assign s_pick_ext = {{INDEX_W{1'b0}}, r_pick};

    always_comb begin
        s_we    = 1'b0;
        s_waddr = s_idx_ext[IDX_W-1:0];
        s_wdata = {1'b0, s_req};
        if (s_accept && (i_command == CMD_LOAD) && s_load_ok) begin
            s_we = 1'b1;
        end else if (s_finish && s_grant) begin
            s_we    = 1'b1;
            s_waddr = r_pick;
            if (s_cfg.fit_policy == POL_WORST) begin
                s_wdata = {r_pick_tk, s_left};
            end else begin
                s_wdata = {1'b1, r_pick_size};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem[s_waddr] <= s_wdata;
        end
        if (r_state == ST_SCAN) begin
            r_rd_word <= mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && (i_command == CMD_ALLOCATE)) begin
                    if ((s_n == '0) || (s_cfg.fit_policy != POL_FIRST &&
                                        s_cfg.fit_policy != POL_BEST &&
                                        s_cfg.fit_policy != POL_WORST)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (s_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            if (s_accept) begin
                r_have <= 1'b0;
            end else if (r_rd_vld && s_take) begin
                r_have <= 1'b1;
            end
            if (s_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_addr <= '0;
            r_req  <= s_req;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        r_rd_idx <= r_addr;
        if (r_rd_vld && s_take) begin
            r_pick      <= r_rd_idx;
            r_pick_size <= s_rd_size;
            r_pick_tk   <= s_rd_tk;
        end
        if (s_finish) begin
            r_out_granted <= s_grant;
            r_out_block   <= s_grant ? s_pick_ext[INDEX_W-1:0] : '0;
            r_out_left    <= s_grant ? s_left_ext[REQ_W-1:0] : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_out_granted;
    assign o_block_number = r_out_block;
    assign o_left_over    = r_out_left;

endmodule

>>> tb/tb_partition_fit_allocator_core.sv
`timescale 1ns / 100ps

module tb_partition_fit_allocator_core;
    import pfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 25;
    localparam logic [ADDR_W-1:0] ADDR_POLICY = {REG_POLICY, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_COUNT  = {REG_COUNT, 2'b00};

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] block;
        logic [REQ_W-1:0]   left;
    } t_grant;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_in_ready;
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] block_index;
    logic [REQ_W-1:0]   req_size;
    logic               o_out_valid;
    logic               out_ready;
    logic               o_granted;
    logic [INDEX_W-1:0] o_block_number;
    logic [REQ_W-1:0]   o_left_over;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic [REQ_W-1:0]   blk_size [NUM_BLOCKS_DEF];
    bit                 blk_taken [NUM_BLOCKS_DEF];
    logic [POL_W-1:0]   cfg_policy;
    logic [COUNT_W-1:0] cfg_count;
    t_grant             expected_grants [$];
    t_grant             exp_grant;

    int  mismatch_count;
    int  idle_cycles;
    int  hold_cycles;
    int  rx_wait;
    bit  idle_on;

    partition_fit_allocator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (command),
        .i_block_index  (block_index),
        .i_size         (req_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_granted      (o_granted),
        .o_block_number (o_block_number),
        .o_left_over    (o_left_over),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                 input logic [REQ_W-1:0] sz);
        int         span;
        bit         found;
        t_grant     g;
        logic [REQ_W-1:0] slack;
        logic [REQ_W-1:0] top;
        span  = (cfg_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(cfg_count);
        found = 1'b0;
        g     = '0;
        if (cmd == CMD_LOAD) begin
            blk_size[idx]  = sz;
            blk_taken[idx] = 1'b0;
        end else begin
            case (cfg_policy)
                POL_FIRST: begin
                    for (int k = 0; k < span; k++) begin
                        if (!found && !blk_taken[k] && blk_size[k] >= sz) begin
                            found   = 1'b1;
                            g.block = INDEX_W'(k);
                            g.left  = blk_size[k] - sz;
                        end
                    end
                    if (found) blk_taken[g.block] = 1'b1;
                end
                POL_BEST: begin
                    for (int k = 0; k < span; k++) begin
                        if (!blk_taken[k] && blk_size[k] >= sz) begin
                            slack = blk_size[k] - sz;
                            if (!found || slack < g.left) begin
                                found   = 1'b1;
                                g.block = INDEX_W'(k);
                                g.left  = slack;
                            end
                        end
                    end
                    if (found) blk_taken[g.block] = 1'b1;
                end
                POL_WORST: begin
                    if (span > 0) begin
                        top = blk_size[0];
                        for (int k = 1; k < span; k++) begin
                            if (blk_size[k] > top) begin
                                top     = blk_size[k];
                                g.block = INDEX_W'(k);
                            end
                        end
                        if (top >= sz) begin
                            found             = 1'b1;
                            g.left            = top - sz;
                            blk_size[g.block] = g.left;
                        end
                    end
                end
                default: found = 1'b0;
            endcase
            if (found) g.granted = 1'b1;
            else g = '0;
            expected_grants.push_back(g);
        end
    endtask

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [REQ_W-1:0] sz);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid    = 1'b1;
        command     = cmd;
        block_index = idx;
        req_size    = sz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_request(cmd, idx, sz);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_POLICY) cfg_policy = data[POL_W-1:0];
        else cfg_count = data[COUNT_W-1:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== data) begin
            $display("%0t: register %0d read expected %0h actual %0h", $time, addr, data, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input int pol, input int cnt);
        wait_for_results();
        cfg_write(ADDR_POLICY, DATA_W'(pol));
        cfg_write(ADDR_COUNT, DATA_W'(cnt));
    endtask

    function automatic logic [REQ_W-1:0] pick_size(input bit for_block);
        int sel;
        sel = $urandom_range(0, 9);
        if (for_block && sel >= 5) return REQ_W'($urandom);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3:    return REQ_W'($urandom_range(0, 255));
            4, 5, 6: return REQ_W'($urandom_range(0, 4095));
            default: return REQ_W'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [REQ_W-1:0] sizes [NUM_BLOCKS_DEF];
        sizes = '{16'd0, 16'hFFFF, 16'd100, 16'd200, 16'd50, 16'd300, 16'd1000, 16'd150,
                  16'd120, 16'd400, 16'd250, 16'd75, 16'd500, 16'd175, 16'd600, 16'hAAAA};
        idle_on = 1'b1;
        for (int k = NUM_BLOCKS_DEF - 1; k >= 0; k--) begin
            send_request(CMD_LOAD, INDEX_W'(k), sizes[k]);
        end
        send_request(CMD_ALLOCATE, 4'd0, 16'd0);
        send_request(CMD_ALLOCATE, 4'd15, 16'hFFFF);
        send_request(CMD_ALLOCATE, 4'd0, 16'd120);
        send_request(CMD_ALLOCATE, 4'd0, 16'hFFFF);
        set_config(POL_BEST, 16);
        send_request(CMD_ALLOCATE, 4'd0, 16'd110);
        send_request(CMD_ALLOCATE, 4'd0, 16'd100);
        set_config(POL_WORST, 16);
        send_request(CMD_ALLOCATE, 4'd0, 16'd0);
        send_request(CMD_ALLOCATE, 4'd0, 16'd1000);
        send_request(CMD_ALLOCATE, 4'd0, 16'hFFFF);
        set_config(3, 16);
        send_request(CMD_ALLOCATE, 4'd0, 16'd5);
        set_config(POL_FIRST, 0);
        send_request(CMD_ALLOCATE, 4'd0, 16'd0);
        set_config(POL_FIRST, 31);
        send_request(CMD_ALLOCATE, 4'd0, 16'd5);
        set_config(POL_WORST, 1);
        send_request(CMD_ALLOCATE, 4'd0, 16'd0);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int pol;
        int cnt;
        for (int p = 0; p < phases; p++) begin
            pol = $urandom_range(0, 12);
            pol = (pol == 12) ? 3 : pol % 3;
            case ($urandom_range(0, 7))
                0:       cnt = 16;
                1:       cnt = 1;
                2:       cnt = 0;
                3:       cnt = $urandom_range(17, 31);
                default: cnt = $urandom_range(1, 16);
            endcase
            set_config(pol, cnt);
            idle_on = (p % 3 != 2);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    send_request(CMD_LOAD, INDEX_W'($urandom_range(0, 15)), pick_size(1'b1));
                end else begin
                    send_request(CMD_ALLOCATE, INDEX_W'($urandom), pick_size(1'b0));
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        set_config(POL_WORST, 16);
        idle_on     = 1'b0;
        hold_cycles = 300;
        for (int n = 0; n < 30; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_request(CMD_LOAD, INDEX_W'($urandom_range(0, 15)), pick_size(1'b1));
            end else begin
                send_request(CMD_ALLOCATE, INDEX_W'($urandom), REQ_W'($urandom_range(0, 255)));
            end
        end
        wait_for_results();
        idle_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_ready = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && out_ready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result granted %0d block %0d left %0d",
                         $time, o_granted, o_block_number, o_left_over);
                mismatch_count++;
            end else begin
                exp_grant = expected_grants.pop_front();
                if (o_granted !== exp_grant.granted) begin
                    $display("%0t: granted expected %0d actual %0d",
                             $time, exp_grant.granted, o_granted);
                    mismatch_count++;
                end
                if (o_block_number !== exp_grant.block) begin
                    $display("%0t: block_number expected %0d actual %0d",
                             $time, exp_grant.block, o_block_number);
                    mismatch_count++;
                end
                if (o_left_over !== exp_grant.left) begin
                    $display("%0t: left_over expected %0d actual %0d",
                             $time, exp_grant.left, o_left_over);
                    mismatch_count++;
                end
            end
            rx_wait = idle_on ? $urandom_range(0, 19) : 0;
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_LOAD;
        block_index    = '0;
        req_size       = '0;
        out_ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cfg_policy     = POL_FIRST;
        cfg_count      = COUNT_RESET;
        mismatch_count = 0;
        hold_cycles    = 0;
        rx_wait        = 0;
        idle_on        = 1'b1;
        foreach (blk_taken[k]) begin
            blk_taken[k] = 1'b0;
            blk_size[k]  = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phases(10, 70);
        test_output_backpressure();
        wait_for_results();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
